// File: hw/rtl/ctde_pkg.sv
// Package with the item types, codes and digit arithmetic of the time digit editor.
package ctde_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BUTTON  = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Status codes of a result item.
    localparam logic [2:0] STATUS_IDLE    = 3'd0;
    localparam logic [2:0] STATUS_EDIT    = 3'd1;
    localparam logic [2:0] STATUS_COMMIT  = 3'd2;
    localparam logic [2:0] STATUS_CANCEL  = 3'd3;
    localparam logic [2:0] STATUS_TIMEOUT = 3'd4;

    // Cursor positions.
    localparam logic [2:0] DIGIT_NONE       = 3'd0;
    localparam logic [2:0] DIGIT_HOUR_TENS  = 3'd1;
    localparam logic [2:0] DIGIT_HOUR_UNITS = 3'd2;
    localparam logic [2:0] DIGIT_MIN_TENS   = 3'd3;
    localparam logic [2:0] DIGIT_MIN_UNITS  = 3'd4;
    localparam logic [2:0] DIGIT_PAST_END   = 3'd5;

    localparam logic [4:0] HOURS_MAX   = 5'd23;
    localparam logic [5:0] MINUTES_MAX = 6'd59;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] load_hours;
        logic [5:0] load_minutes;
        logic       btn_next;
        logic       btn_back;
        logic       btn_up;
        logic       btn_down;
    } cmd_item_t;

    typedef struct packed {
        logic [4:0] edit_hours;
        logic [5:0] edit_minutes;
        logic [2:0] cursor_digit;
        logic [2:0] status;
    } rsp_item_t;

    typedef struct packed {
        logic       active;
        logic [2:0] cursor;
        logic [4:0] hours;
        logic [5:0] minutes;
    } edit_state_t;

    function automatic logic [1:0] hours_tens(input logic [4:0] h);
        logic [1:0] t;
        if (h >= 5'd20)
            t = 2'd2;
        else if (h >= 5'd10)
            t = 2'd1;
        else
            t = 2'd0;
        return t;
    endfunction

    function automatic logic [4:0] hours_units(input logic [4:0] h);
        return 5'(h - 5'(hours_tens(h)) * 5'd10);
    endfunction

    function automatic logic [2:0] minutes_tens(input logic [5:0] m);
        logic [2:0] t;
        if (m >= 6'd60)
            t = 3'd6;
        else if (m >= 6'd50)
            t = 3'd5;
        else if (m >= 6'd40)
            t = 3'd4;
        else if (m >= 6'd30)
            t = 3'd3;
        else if (m >= 6'd20)
            t = 3'd2;
        else if (m >= 6'd10)
            t = 3'd1;
        else
            t = 3'd0;
        return t;
    endfunction

    function automatic logic [5:0] minutes_units(input logic [5:0] m);
        return 6'(m - 6'(minutes_tens(m)) * 6'd10);
    endfunction

    // Highest units digit of hours: 9 below twenty, 3 from twenty on.
    function automatic logic [4:0] hours_units_max(input logic [1:0] t);
        return (t < 2'd2) ? 5'd9 : 5'd3;
    endfunction

    function automatic logic [4:0] hours_up(input logic [2:0] cur, input logic [4:0] h);
        logic [1:0] t;
        logic [4:0] u;
        logic [4:0] r;
        t = hours_tens(h);
        u = hours_units(h);
        r = h;
        if (cur == DIGIT_HOUR_TENS)
            r = (t < 2'd2) ? 5'(h + 5'd10) : u;
        else if (cur == DIGIT_HOUR_UNITS)
            r = (u < hours_units_max(t)) ? 5'(h + 5'd1) : 5'(5'(t) * 5'd10);
        return r;
    endfunction

    function automatic logic [4:0] hours_down(input logic [2:0] cur, input logic [4:0] h);
        logic [1:0] t;
        logic [4:0] u;
        logic [4:0] r;
        t = hours_tens(h);
        u = hours_units(h);
        r = h;
        if (cur == DIGIT_HOUR_TENS)
            r = (t > 2'd0) ? 5'(h - 5'd10) : 5'(u + 5'd20);
        else if (cur == DIGIT_HOUR_UNITS)
            r = (u > 5'd0) ? 5'(h - 5'd1) : 5'(5'(t) * 5'd10 + hours_units_max(t));
        return r;
    endfunction

    function automatic logic [5:0] minutes_up(input logic [2:0] cur, input logic [5:0] m);
        logic [2:0] t;
        logic [5:0] u;
        logic [5:0] r;
        t = minutes_tens(m);
        u = minutes_units(m);
        r = m;
        if (cur == DIGIT_MIN_TENS)
            r = (t < 3'd5) ? 6'(m + 6'd10) : u;
        else if (cur == DIGIT_MIN_UNITS)
            r = (u < 6'd9) ? 6'(m + 6'd1) : 6'(6'(t) * 6'd10);
        return r;
    endfunction

    function automatic logic [5:0] minutes_down(input logic [2:0] cur, input logic [5:0] m);
        logic [2:0] t;
        logic [5:0] u;
        logic [5:0] r;
        t = minutes_tens(m);
        u = minutes_units(m);
        r = m;
        if (cur == DIGIT_MIN_TENS)
            r = (t > 3'd0) ? 6'(m - 6'd10) : 6'(u + 6'd50);
        else if (cur == DIGIT_MIN_UNITS)
            r = (u > 6'd0) ? 6'(m - 6'd1) : 6'(6'(t) * 6'd10 + 6'd9);
        return r;
    endfunction

endpackage

// File: hw/rtl/ctde_if.sv
// Valid/ready channel interfaces for the command and response items.
interface ctde_cmd_if;
    logic                valid;
    logic                ready;
    ctde_pkg::cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ctde_rsp_if;
    logic                valid;
    logic                ready;
    ctde_pkg::rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/ctde_step.sv
// Next-state and result logic of the editor for one command item.
module ctde_step
(
    input  ctde_pkg::edit_state_t state,
    input  ctde_pkg::cmd_item_t   item,
    output ctde_pkg::edit_state_t state_next,
    output ctde_pkg::rsp_item_t   result
);

    logic [2:0] cur;
    logic [4:0] h;
    logic [5:0] m;
    logic       cancel;
    logic [2:0] status;

    always_comb
    begin
        state_next = state;
        status     = state.active ? ctde_pkg::STATUS_EDIT : ctde_pkg::STATUS_IDLE;
        cur        = state.cursor;
        h          = state.hours;
        m          = state.minutes;
        cancel     = 1'b0;

        unique case (item.operation)
            ctde_pkg::OP_START:
            begin
                state_next.hours   = (item.load_hours > ctde_pkg::HOURS_MAX) ?
                                     ctde_pkg::HOURS_MAX : item.load_hours;
                state_next.minutes = (item.load_minutes > ctde_pkg::MINUTES_MAX) ?
                                     ctde_pkg::MINUTES_MAX : item.load_minutes;
                state_next.cursor  = ctde_pkg::DIGIT_HOUR_TENS;
                state_next.active  = 1'b1;
                status             = ctde_pkg::STATUS_EDIT;
            end
            ctde_pkg::OP_BUTTON:
            begin
                if (state.active)
                begin
                    // Buttons act in the order next, back, up, down.
                    if (item.btn_next)
                    begin
                        if (cur == ctde_pkg::DIGIT_HOUR_TENS && h > ctde_pkg::HOURS_MAX)
                            h = ctde_pkg::HOURS_MAX;
                        cur = 3'(cur + 3'd1);
                    end
                    if (item.btn_back)
                    begin
                        if (cur > ctde_pkg::DIGIT_HOUR_TENS)
                            cur = 3'(cur - 3'd1);
                        else
                            cancel = 1'b1;
                    end
                    if (cancel)
                    begin
                        state_next.hours  = h;
                        state_next.active = 1'b0;
                        state_next.cursor = ctde_pkg::DIGIT_NONE;
                        status            = ctde_pkg::STATUS_CANCEL;
                    end
                    else
                    begin
                        if (item.btn_up)
                        begin
                            h = ctde_pkg::hours_up(cur, h);
                            m = ctde_pkg::minutes_up(cur, m);
                        end
                        if (item.btn_down)
                        begin
                            h = ctde_pkg::hours_down(cur, h);
                            m = ctde_pkg::minutes_down(cur, m);
                        end
                        state_next.hours   = h;
                        state_next.minutes = m;
                        state_next.cursor  = cur;
                        if (cur > ctde_pkg::DIGIT_MIN_UNITS)
                        begin
                            state_next.active = 1'b0;
                            status            = ctde_pkg::STATUS_COMMIT;
                        end
                    end
                end
            end
            ctde_pkg::OP_TIMEOUT:
            begin
                if (state.active)
                begin
                    state_next.active = 1'b0;
                    state_next.cursor = ctde_pkg::DIGIT_NONE;
                    status            = ctde_pkg::STATUS_TIMEOUT;
                end
            end
            default:
            begin
                // Unused operation code: no change.
            end
        endcase

        result.edit_hours   = state_next.hours;
        result.edit_minutes = state_next.minutes;
        result.status       = status;
        if (status == ctde_pkg::STATUS_COMMIT)
        begin
            result.cursor_digit = ctde_pkg::DIGIT_PAST_END;
            state_next.cursor   = ctde_pkg::DIGIT_NONE;
        end
        else
        begin
            result.cursor_digit = state_next.active ? state_next.cursor : ctde_pkg::DIGIT_NONE;
        end
    end

endmodule

// File: hw/rtl/clock_time_digit_editor.sv
// Top level of the button-driven HH:MM time digit editor.
//
//  Channel | Direction | Payload                                   | Handshake
//  --------+-----------+-------------------------------------------+------------
//  cmd     | in        | operation, load time, four button flags   | valid/ready
//  rsp     | out       | edit hours/minutes, cursor digit, status  | valid/ready
//
// Each accepted command item produces exactly one response item, written into the
// response register on acceptance. The editor state and the response register are
// written in the same cycle, so a new item is taken every cycle while the
// response register is empty or being drained; throughput is one item per
// clock, limited only by the single response register.
// Reset (rst_n low, asynchronous) returns the editor to idle with zero time
// and an empty response register. A stalled response blocks only new items.
module clock_time_digit_editor
(
    input  logic              clk,
    input  logic              rst_n,
    ctde_cmd_if.sink          cmd,
    ctde_rsp_if.source        rsp
);

    ctde_pkg::edit_state_t state_reg;
    ctde_pkg::edit_state_t state_next;
    ctde_pkg::rsp_item_t   result_next;
    ctde_pkg::rsp_item_t   result_reg;
    logic                  rsp_valid_reg;
    logic                  accept;

    // A new item is taken when the response register is free or is being
    // emptied in this same cycle.
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    ctde_step u_step
    (
        .state      (state_reg),
        .item       (cmd.data),
        .state_next (state_next),
        .result     (result_next)
    );

    // Editor state: session flag, cursor and working time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Response valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload holds while the consumer stalls.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = result_reg;

endmodule

// File: sim/time_editor_checker.sv
// Checker that predicts each response of the time digit editor and compares it field by field.
module time_editor_checker
    import ctde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ctde_cmd_if  cmd,
    ctde_rsp_if  rsp,
    output int   fail_count,
    output int   outstanding,
    output logic session_open
);

    logic       editing     = 1'b0;
    logic [2:0] digit_sel   = DIGIT_NONE;
    logic [4:0] hours_now   = '0;
    logic [5:0] minutes_now = '0;
    int         errors      = 0;
    int         waiting     = 0;
    rsp_item_t  due_rsp[$];

    assign fail_count   = errors;
    assign outstanding  = waiting;
    assign session_open = editing;

    // Steps the selected digit up or down, wrapping within the range of that digit.
    function automatic void turn_digit(input bit up);
        int ht;
        int hu;
        int mt;
        int mu;
        int hu_top;
        ht     = int'(hours_now) / 10;
        hu     = int'(hours_now) % 10;
        mt     = int'(minutes_now) / 10;
        mu     = int'(minutes_now) % 10;
        hu_top = (ht < 2) ? 9 : 3;
        case (digit_sel)
            DIGIT_HOUR_TENS:
                if (up)
                    hours_now = 5'((ht < 2) ? int'(hours_now) + 10 : hu);
                else
                    hours_now = 5'((ht > 0) ? int'(hours_now) - 10 : hu + 20);
            DIGIT_HOUR_UNITS:
                if (up)
                    hours_now = 5'((hu < hu_top) ? int'(hours_now) + 1 : ht * 10);
                else
                    hours_now = 5'((hu > 0) ? int'(hours_now) - 1 : ht * 10 + hu_top);
            DIGIT_MIN_TENS:
                if (up)
                    minutes_now = 6'((mt < 5) ? int'(minutes_now) + 10 : mu);
                else
                    minutes_now = 6'((mt > 0) ? int'(minutes_now) - 10 : mu + 50);
            DIGIT_MIN_UNITS:
                if (up)
                    minutes_now = 6'((mu < 9) ? int'(minutes_now) + 1 : mt * 10);
                else
                    minutes_now = 6'((mu > 0) ? int'(minutes_now) - 1 : mt * 10 + 9);
            default:
                ;
        endcase
    endfunction

    // Applies one command to the shadow editor state and returns the response it yields.
    function automatic rsp_item_t edit_step(input cmd_item_t c);
        rsp_item_t  r;
        logic [2:0] st;
        logic       cancel;
        cancel = 1'b0;
        if (c.operation == OP_START)
        begin
            hours_now   = (c.load_hours > HOURS_MAX) ? HOURS_MAX : c.load_hours;
            minutes_now = (c.load_minutes > MINUTES_MAX) ? MINUTES_MAX : c.load_minutes;
            digit_sel   = DIGIT_HOUR_TENS;
            editing     = 1'b1;
            st          = STATUS_EDIT;
        end
        else if (c.operation == OP_BUTTON && editing)
        begin
            st = STATUS_EDIT;
            if (c.btn_next)
            begin
                if (digit_sel == DIGIT_HOUR_TENS && hours_now > HOURS_MAX)
                    hours_now = HOURS_MAX;
                digit_sel = digit_sel + 3'd1;
            end
            if (c.btn_back)
            begin
                if (digit_sel > DIGIT_HOUR_TENS)
                    digit_sel = digit_sel - 3'd1;
                else
                    cancel = 1'b1;
            end
            if (cancel)
            begin
                editing   = 1'b0;
                digit_sel = DIGIT_NONE;
                st        = STATUS_CANCEL;
            end
            else
            begin
                if (c.btn_up)
                    turn_digit(1'b1);
                if (c.btn_down)
                    turn_digit(1'b0);
                if (digit_sel > DIGIT_MIN_UNITS)
                begin
                    editing = 1'b0;
                    st      = STATUS_COMMIT;
                end
            end
        end
        else if (c.operation == OP_TIMEOUT && editing)
        begin
            editing   = 1'b0;
            digit_sel = DIGIT_NONE;
            st        = STATUS_TIMEOUT;
        end
        else
        begin
            st = editing ? STATUS_EDIT : STATUS_IDLE;
        end

        r.edit_hours   = hours_now;
        r.edit_minutes = minutes_now;
        if (st == STATUS_COMMIT)
        begin
            r.cursor_digit = DIGIT_PAST_END;
            digit_sel      = DIGIT_NONE;
        end
        else
        begin
            r.cursor_digit = editing ? digit_sel : DIGIT_NONE;
        end
        r.status = st;
        return r;
    endfunction

    function automatic void check_rsp(input rsp_item_t got, input rsp_item_t want);
        if (got.edit_hours !== want.edit_hours)
        begin
            $error("edit_hours: expected %0d, got %0d", want.edit_hours, got.edit_hours);
            errors++;
        end
        if (got.edit_minutes !== want.edit_minutes)
        begin
            $error("edit_minutes: expected %0d, got %0d", want.edit_minutes, got.edit_minutes);
            errors++;
        end
        if (got.cursor_digit !== want.cursor_digit)
        begin
            $error("cursor_digit: expected %0d, got %0d", want.cursor_digit, got.cursor_digit);
            errors++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
    endfunction

    // The response taken at an edge always belongs to an earlier command, so it is
    // checked before the command accepted at the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            editing     = 1'b0;
            digit_sel   = DIGIT_NONE;
            hours_now   = '0;
            minutes_now = '0;
            due_rsp.delete();
            waiting     = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    $error("response item arrived with no command waiting for it");
                    errors++;
                end
                else
                begin
                    check_rsp(rsp.data, due_rsp.pop_front());
                end
            end
            if (cmd.valid && cmd.ready)
                due_rsp.push_back(edit_step(cmd.data));
            waiting = due_rsp.size();
        end
    end

endmodule

// File: sim/testbench.sv
// Top of the time digit editor testbench: clock, reset, command stimulus and the verdict.
module testbench;
    import ctde_pkg::*;

    // Operation code with no meaning; the editor must ignore it.
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int CMD_BITS    = $bits(cmd_item_t);
    localparam int PHASE_ITEMS = 175;
    localparam int MAX_PRESSES = 48;

    // Idling phases: sender idle percentage and receiver stall percentage.
    localparam int IDLE_PLAN[4]  = '{0, 81, 0, 29};
    localparam int STALL_PLAN[4] = '{0, 0, 81, 29};

    logic clk = 1'b0;
    logic rst_n;
    logic session_open;
    int   fail_count;
    int   outstanding;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   applied   = 0;

    ctde_cmd_if cmd_ch ();
    ctde_rsp_if rsp_ch ();

    clock_time_digit_editor uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // The checker watches both channels, predicts every response and counts the
    // mismatches. It also tells the stimulus whether an edit session is open, so
    // the random part can keep pressing buttons while a session lasts, up to MAX_PRESSES.
    time_editor_checker edit_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .session_open (session_open)
    );

    always #10 clk = ~clk;

    // The receiver decides once per cycle, at the falling edge, whether it stalls.
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

    function automatic cmd_item_t start_item(input int hours, input int minutes);
        cmd_item_t c;
        c              = '0;
        c.operation    = OP_START;
        c.load_hours   = 5'(hours);
        c.load_minutes = 6'(minutes);
        return c;
    endfunction

    function automatic cmd_item_t button_item(input bit nxt, input bit bck, input bit up,
                                              input bit dn);
        cmd_item_t c;
        c           = '0;
        c.operation = OP_BUTTON;
        c.btn_next  = nxt;
        c.btn_back  = bck;
        c.btn_up    = up;
        c.btn_down  = dn;
        return c;
    endfunction

    function automatic cmd_item_t bare_item(input logic [1:0] op);
        cmd_item_t c;
        c           = '0;
        c.operation = op;
        return c;
    endfunction

    // Offers one item on the command channel. Before it the sender may idle for a
    // while; valid is then dropped at one falling edge and raised at a later one,
    // never both in the same step. Returns at the falling edge after acceptance.
    // Items that reach an open session, and every start, are counted as applied.
    task automatic send_cmd(input cmd_item_t item);
        if (session_open || item.operation == OP_START)
            applied++;
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= item;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds the sender back until every response that is owed has come out.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    // A short walk over the corners: ignored items while idle, clamping of loaded
    // values, hours above 23 while on the tens digit, wrapping of every digit in
    // both directions (the hour tens down only), next and back in one event, cancel
    // with a press that must be ignored, a commit, a restart and a timeout while editing.
    task automatic run_directed();
        cmd_item_t plan[$];
        plan.push_back(button_item(1, 1, 1, 1));    // buttons while idle
        plan.push_back(bare_item(OP_TIMEOUT));      // timeout while idle
        plan.push_back(bare_item(OP_RESERVED));     // reserved code while idle
        plan.push_back(start_item(31, 63));         // loads clamp to 23:59
        plan.push_back(bare_item(OP_RESERVED));     // reserved code while editing
        plan.push_back(button_item(0, 0, 0, 0));    // event with no button
        plan.push_back(start_item(9, 0));           // restart while editing
        plan.push_back(button_item(0, 0, 1, 0));    // 09 -> 19
        plan.push_back(button_item(0, 0, 1, 0));    // 19 -> 29, above 23 for now
        plan.push_back(button_item(1, 0, 0, 0));    // leaving the tens clamps to 23
        plan.push_back(button_item(0, 0, 1, 0));    // units wrap up: 23 -> 20
        plan.push_back(button_item(0, 0, 0, 1));    // units wrap down: 20 -> 23
        plan.push_back(button_item(1, 1, 0, 0));    // next and back cancel out
        plan.push_back(button_item(0, 1, 0, 0));    // back to the tens digit
        plan.push_back(button_item(0, 0, 0, 1));    // 23 -> 13
        plan.push_back(button_item(0, 0, 0, 1));    // 13 -> 03
        plan.push_back(button_item(0, 0, 0, 1));    // tens wrap down: 03 -> 23
        plan.push_back(button_item(0, 1, 1, 0));    // cancel, the up press is dropped
        plan.push_back(start_item(0, 59));
        plan.push_back(button_item(1, 0, 0, 0));
        plan.push_back(button_item(1, 0, 1, 0));    // minute tens wrap up: 59 -> 09
        plan.push_back(button_item(0, 0, 0, 1));    // minute tens wrap down: 09 -> 59
        plan.push_back(button_item(1, 0, 1, 0));    // minute units wrap up: 59 -> 50
        plan.push_back(button_item(1, 1, 0, 1));    // no commit, units wrap down: 50 -> 59
        plan.push_back(button_item(1, 0, 0, 1));    // commit; the down press finds no digit
        plan.push_back(start_item(12, 30));
        plan.push_back(bare_item(OP_TIMEOUT));      // timeout while editing
        foreach (plan[i])
            send_cmd(plan[i]);
    endtask

    // One random session: a start with mostly legal times, then button events with
    // random content until the session ends by commit, cancel or timeout, closed by a
    // timeout after MAX_PRESSES events. Now and then a timeout, a restart or a reserved
    // code breaks in. One time in ten the whole session is replaced by one item of pure noise.
    task automatic random_session();
        cmd_item_t item;
        int        presses;
        int        roll;
        if ($urandom_range(9) == 0)
        begin
            item = cmd_item_t'(CMD_BITS'($urandom));
            send_cmd(item);
        end
        else
        begin
            if ($urandom_range(7) == 0)
                item = start_item($urandom_range(31), $urandom_range(63));
            else
                item = start_item($urandom_range(23), $urandom_range(59));
            send_cmd(item);
            presses = 0;
            while (session_open && presses < MAX_PRESSES)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    item = bare_item(OP_TIMEOUT);
                else if (roll < 5)
                    item = start_item($urandom_range(31), $urandom_range(63));
                else if (roll < 7)
                    item = bare_item(OP_RESERVED);
                else
                    item = button_item($urandom_range(99) < 30, $urandom_range(99) < 8,
                                       $urandom_range(99) < 40, $urandom_range(99) < 40);
                // The load fields are don't-care outside a start; toggle them anyway.
                if (item.operation != OP_START)
                begin
                    item.load_hours   = 5'($urandom);
                    item.load_minutes = 6'($urandom);
                end
                send_cmd(item);
                presses++;
            end
            if (session_open)
                send_cmd(bare_item(OP_TIMEOUT));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        // The sender pauses here until the directed responses have all come out.
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = IDLE_PLAN[p];
            stall_pct = STALL_PLAN[p];
            applied   = 0;
            while (applied < PHASE_ITEMS)
                random_session();
            wait_drained();
        end

        // The wait lets a stray response show up before the verdict.
        repeat (4)
            @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS clock_time_digit_editor");
        else
            $display("FAIL clock_time_digit_editor");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #8000000;
        $display("FAIL clock_time_digit_editor");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ctde_pkg.sv
hw/rtl/ctde_if.sv
hw/rtl/ctde_step.sv
hw/rtl/clock_time_digit_editor.sv
sim/time_editor_checker.sv
sim/testbench.sv
